[rtl/core/dvu_pkg.sv]
// ---------------------------------------------------------------------------
// dvu_pkg
// Shared types and constants of the distance vector update unit.
// ---------------------------------------------------------------------------
`default_nettype none

package dvu_pkg;

    localparam int NODES     = 16;
    localparam int IDX_W     = 4;
    localparam int COST_BITS = 16;
    localparam int HOP_W     = IDX_W + 1;
    localparam int TBL_DEPTH = NODES * NODES;
    localparam int TBL_AW    = 2 * IDX_W;

    localparam logic [IDX_W-1:0]            LAST_IDX  = IDX_W'(NODES - 1);
    localparam logic signed [COST_BITS-1:0] COST_MAX  = {1'b0, {(COST_BITS-1){1'b1}}};
    localparam logic signed [COST_BITS-1:0] COST_NONE = '1;
    localparam logic signed [HOP_W-1:0]     HOP_NONE  = '1;

    typedef enum logic [1:0] {
        REQ_LINK   = 2'd0,
        REQ_NBR    = 2'd1,
        REQ_RECOMP = 2'd2,
        REQ_NOP    = 2'd3
    } req_type_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_RELAX,
        ST_DRAIN,
        ST_UPDATE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic             start;
        logic             init;
        logic             issue;
        logic             update;
        logic [IDX_W-1:0] dest;
        logic [IDX_W-1:0] nbr;
    } cmd_t;

endpackage

`default_nettype wire

[rtl/core/dvu_req_if.sv]
// ---------------------------------------------------------------------------
// dvu_req_if
// Request channel: table loads and recompute commands.
// ---------------------------------------------------------------------------
`default_nettype none

interface dvu_req_if;

    logic                                    valid;
    logic                                    ready;
    logic [1:0]                              req_type;
    logic [dvu_pkg::IDX_W-1:0]               node_index;
    logic [dvu_pkg::IDX_W-1:0]               dest_index;
    logic signed [dvu_pkg::COST_BITS-1:0]    cost_value;

    modport source (
        output valid,
        output req_type,
        output node_index,
        output dest_index,
        output cost_value,
        input  ready
    );

    modport sink (
        input  valid,
        input  req_type,
        input  node_index,
        input  dest_index,
        input  cost_value,
        output ready
    );

endinterface

`default_nettype wire

[rtl/core/dvu_rsp_if.sv]
// ---------------------------------------------------------------------------
// dvu_rsp_if
// Result channel: one item per destination after a recompute.
// ---------------------------------------------------------------------------
`default_nettype none

interface dvu_rsp_if;

    logic                                    valid;
    logic                                    ready;
    logic [dvu_pkg::IDX_W-1:0]               out_dest;
    logic signed [dvu_pkg::COST_BITS-1:0]    out_cost;
    logic signed [dvu_pkg::HOP_W-1:0]        out_next_hop;
    logic                                    vector_changed;
    logic                                    last_entry;

    modport source (
        output valid,
        output out_dest,
        output out_cost,
        output out_next_hop,
        output vector_changed,
        output last_entry,
        input  ready
    );

    modport sink (
        input  valid,
        input  out_dest,
        input  out_cost,
        input  out_next_hop,
        input  vector_changed,
        input  last_entry,
        output ready
    );

endinterface

`default_nettype wire

[rtl/core/dvu_ctrl.sv]
// ---------------------------------------------------------------------------
// dvu_ctrl
// Sequencer: walks destinations and neighbors for a recompute, then emits
// one result item per destination.
// ---------------------------------------------------------------------------
`default_nettype none

module dvu_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_acc,
    input  wire logic [1:0]    req_type,
    input  wire logic          rsp_acc,
    output logic               req_ready,
    output logic               rsp_valid,
    output logic               rsp_last,
    output dvu_pkg::cmd_t      cmd
);

    dvu_pkg::state_t                  state_reg;
    dvu_pkg::state_t                  state_next;
    logic [dvu_pkg::IDX_W-1:0]        j_reg;
    logic [dvu_pkg::IDX_W-1:0]        j_next;
    logic [dvu_pkg::IDX_W-1:0]        k_reg;
    logic [dvu_pkg::IDX_W-1:0]        k_next;
    logic                             start;

    assign start = req_acc && (req_type == dvu_pkg::REQ_RECOMP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dvu_pkg::ST_IDLE;
            j_reg     <= '0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            j_reg     <= j_next;
            k_reg     <= k_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dvu_pkg::ST_IDLE:
            begin
                if (start)
                    state_next = dvu_pkg::ST_INIT;
            end
            dvu_pkg::ST_INIT:
                state_next = dvu_pkg::ST_RELAX;
            dvu_pkg::ST_RELAX:
            begin
                if (k_reg == dvu_pkg::LAST_IDX)
                    state_next = dvu_pkg::ST_DRAIN;
            end
            dvu_pkg::ST_DRAIN:
                state_next = dvu_pkg::ST_UPDATE;
            dvu_pkg::ST_UPDATE:
            begin
                if (j_reg == dvu_pkg::LAST_IDX)
                    state_next = dvu_pkg::ST_EMIT;
                else
                    state_next = dvu_pkg::ST_INIT;
            end
            dvu_pkg::ST_EMIT:
            begin
                if (rsp_acc && (j_reg == dvu_pkg::LAST_IDX))
                    state_next = dvu_pkg::ST_IDLE;
            end
            default:
                state_next = dvu_pkg::ST_IDLE;
        endcase
    end

    // advance destination and neighbor counters
    always_comb
    begin
        j_next = j_reg;
        k_next = k_reg;
        case (state_reg)
            dvu_pkg::ST_IDLE:
            begin
                if (start)
                    j_next = '0;
            end
            dvu_pkg::ST_INIT:
                k_next = '0;
            dvu_pkg::ST_RELAX:
                k_next = k_reg + 1'b1;
            dvu_pkg::ST_UPDATE:
                j_next = (j_reg == dvu_pkg::LAST_IDX) ? '0 : j_reg + 1'b1;
            dvu_pkg::ST_EMIT:
            begin
                if (rsp_acc && (j_reg != dvu_pkg::LAST_IDX))
                    j_next = j_reg + 1'b1;
            end
            default:
            begin
                j_next = j_reg;
                k_next = k_reg;
            end
        endcase
    end

    always_comb
    begin
        req_ready  = 1'b0;
        rsp_valid  = 1'b0;
        rsp_last   = 1'b0;
        cmd.start  = 1'b0;
        cmd.init   = 1'b0;
        cmd.issue  = 1'b0;
        cmd.update = 1'b0;
        cmd.dest   = j_reg;
        cmd.nbr    = k_reg;
        unique case (state_reg)
            dvu_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                cmd.start = start;
            end
            dvu_pkg::ST_INIT:
                cmd.init = 1'b1;
            dvu_pkg::ST_RELAX:
                cmd.issue = 1'b1;
            dvu_pkg::ST_DRAIN:
                cmd.issue = 1'b0;
            dvu_pkg::ST_UPDATE:
                cmd.update = 1'b1;
            dvu_pkg::ST_EMIT:
            begin
                rsp_valid = 1'b1;
                rsp_last  = (j_reg == dvu_pkg::LAST_IDX);
            end
            default:
                req_ready = 1'b0;
        endcase
    end

endmodule

`default_nettype wire

[rtl/core/dvu_datapath.sv]
// ---------------------------------------------------------------------------
// dvu_datapath
// Link row, neighbor table memory, previous vector, next-hop row and the
// relaxation compare-and-select.
// ---------------------------------------------------------------------------
`default_nettype none

module dvu_datapath (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   cfg_we,
    input  wire logic [dvu_pkg::IDX_W-1:0]              cfg_wdata,
    input  wire logic                                   req_acc,
    input  wire logic [1:0]                             req_type,
    input  wire logic [dvu_pkg::IDX_W-1:0]              node_index,
    input  wire logic [dvu_pkg::IDX_W-1:0]              dest_index,
    input  wire logic signed [dvu_pkg::COST_BITS-1:0]   cost_value,
    input  wire dvu_pkg::cmd_t                          cmd,
    output logic signed [dvu_pkg::COST_BITS-1:0]        out_cost,
    output logic signed [dvu_pkg::HOP_W-1:0]            out_next_hop,
    output logic                                        out_changed
);

    localparam int CB = dvu_pkg::COST_BITS;

    logic [dvu_pkg::IDX_W-1:0]        self_id_reg;
    logic signed [CB-1:0]             link_reg [dvu_pkg::NODES];
    logic signed [CB-1:0]             prev_reg [dvu_pkg::NODES];
    logic signed [dvu_pkg::HOP_W-1:0] hop_reg  [dvu_pkg::NODES];
    logic [dvu_pkg::TBL_DEPTH-1:0]    vld_reg;
    logic signed [CB-1:0]             tbl_mem  [dvu_pkg::TBL_DEPTH];
    logic signed [CB-1:0]             rd_data_reg;
    logic                             rd_vld_reg;
    logic                             s1_valid_reg;
    logic [dvu_pkg::IDX_W-1:0]        s1_k_reg;
    logic signed [CB-1:0]             s1_link_reg;
    logic signed [CB-1:0]             x_reg;
    logic signed [dvu_pkg::HOP_W-1:0] hopw_reg;
    logic                             changed_reg;

    logic                             load_link;
    logic                             load_nbr;
    logic [dvu_pkg::TBL_AW-1:0]       wr_addr;
    logic [dvu_pkg::TBL_AW-1:0]       rd_addr;
    logic signed [CB-1:0]             adv;
    logic [CB:0]                      sum;
    logic signed [CB-1:0]             cand;
    logic signed [dvu_pkg::HOP_W-1:0] s1_hop;
    logic                             usable;
    logic                             take;

    assign load_link = req_acc && (req_type == dvu_pkg::REQ_LINK);
    assign load_nbr  = req_acc && (req_type == dvu_pkg::REQ_NBR);
    assign wr_addr   = {node_index, dest_index};
    assign rd_addr   = {cmd.nbr, cmd.dest};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            self_id_reg  <= '0;
            changed_reg  <= 1'b0;
            vld_reg      <= '0;
            rd_vld_reg   <= 1'b0;
            s1_valid_reg <= 1'b0;
            for (int i = 0; i < dvu_pkg::NODES; i++)
            begin
                link_reg[i] <= dvu_pkg::COST_NONE;
                prev_reg[i] <= dvu_pkg::COST_NONE;
                hop_reg[i]  <= dvu_pkg::HOP_NONE;
            end
        end
        else
        begin
            if (cfg_we)
                self_id_reg <= cfg_wdata;
            if (load_link)
            begin
                link_reg[node_index] <= cost_value;
                prev_reg[node_index] <= cost_value;
                hop_reg[node_index]  <= cost_value[CB-1] ? dvu_pkg::HOP_NONE
                                                         : {1'b0, node_index};
            end
            if (load_nbr)
                vld_reg[wr_addr] <= 1'b1;
            rd_vld_reg   <= vld_reg[rd_addr];
            s1_valid_reg <= cmd.issue;
            if (cmd.start)
                changed_reg <= 1'b0;
            if (cmd.update)
            begin
                if (x_reg != prev_reg[cmd.dest])
                    changed_reg <= 1'b1;
                prev_reg[cmd.dest] <= x_reg;
                hop_reg[cmd.dest]  <= hopw_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_nbr)
            tbl_mem[wr_addr] <= cost_value;
        rd_data_reg <= tbl_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        s1_k_reg    <= cmd.nbr;
        s1_link_reg <= link_reg[cmd.nbr];
        if (cmd.init)
        begin
            x_reg    <= link_reg[cmd.dest];
            hopw_reg <= hop_reg[cmd.dest];
        end
        else if (take)
        begin
            x_reg    <= cand;
            hopw_reg <= s1_hop;
        end
    end

    // relax through the neighbor held in stage one
    always_comb
    begin
        adv    = rd_vld_reg ? rd_data_reg : dvu_pkg::COST_NONE;
        s1_hop = {1'b0, s1_k_reg};
        usable = s1_valid_reg && (s1_k_reg != self_id_reg)
                 && !s1_link_reg[CB-1] && !adv[CB-1];
        sum    = {1'b0, s1_link_reg} + {1'b0, adv};
        cand   = (sum > {1'b0, dvu_pkg::COST_MAX}) ? dvu_pkg::COST_MAX : sum[CB-1:0];
        take   = usable && (x_reg[CB-1] || (x_reg > cand)
                 || ((x_reg == cand) && (hopw_reg != s1_hop) && (s1_k_reg == cmd.dest)));
    end

    assign out_cost     = prev_reg[cmd.dest];
    assign out_next_hop = hop_reg[cmd.dest];
    assign out_changed  = changed_reg;

endmodule

`default_nettype wire

[rtl/core/distance_vector_update_unit.sv]
// ---------------------------------------------------------------------------
// distance_vector_update_unit
// Distance-vector recompute engine for one router.
//
//   channel  dir  handshake          carries
//   req      in   valid/ready        req_type, node_index, dest_index, cost_value
//   rsp      out  valid/ready        out_dest, out_cost, out_next_hop, flags
//   cfg      in   cfg_we             cfg_wdata (self_id)
//
// Link and neighbor loads are accepted back to back.
// In a recompute the relax loop reads one neighbor table entry per cycle
// from the memory's single read port.
// Then NODES result items follow, one per cycle while rsp.ready is high.
// req.ready is low from the recompute item until the last result is taken.
// Reset restores all costs and hops to unreachable; no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module distance_vector_update_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [dvu_pkg::IDX_W-1:0]     cfg_wdata,
    dvu_req_if.sink                            req,
    dvu_rsp_if.source                          rsp
);

    dvu_pkg::cmd_t  cmd;
    logic           req_acc;
    logic           rsp_acc;
    logic           rsp_last;
    logic           changed;

    assign req_acc = req.valid && req.ready;
    assign rsp_acc = rsp.valid && rsp.ready;

    dvu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_acc   (req_acc),
        .req_type  (req.req_type),
        .rsp_acc   (rsp_acc),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_last  (rsp_last),
        .cmd       (cmd)
    );

    dvu_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .req_acc      (req_acc),
        .req_type     (req.req_type),
        .node_index   (req.node_index),
        .dest_index   (req.dest_index),
        .cost_value   (req.cost_value),
        .cmd          (cmd),
        .out_cost     (rsp.out_cost),
        .out_next_hop (rsp.out_next_hop),
        .out_changed  (changed)
    );

    assign rsp.out_dest       = cmd.dest;
    assign rsp.last_entry     = rsp_last;
    assign rsp.vector_changed = rsp_last && changed;

    a_last_frees_req: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_acc && rsp.last_entry |=> req.ready)
        else $error("req not ready after last result item");

    a_recomp_blocks_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc && (req.req_type == dvu_pkg::REQ_RECOMP) |=> !req.ready && !rsp.valid)
        else $error("recompute did not hold off the channels");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(req.ready && rsp.valid))
        else $error("request accepted while results pending");

    a_last_dest: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.last_entry == (rsp.out_dest == dvu_pkg::LAST_IDX)))
        else $error("last flag out of step with destination");

    a_dest_order: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_acc && !rsp.last_entry |=> rsp.out_dest == $past(rsp.out_dest) + 1'b1)
        else $error("result items out of destination order");

endmodule

`default_nettype wire

[sim/tb_distance_vector_update_unit.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_distance_vector_update_unit
// Self-checking bench for the distance vector update unit. A queue-fed
// driver sends link loads, neighbor entries, recomputes and no-op requests
// with random gaps. A shadow routing table predicts the per-destination
// results of every recompute. A monitor with random stalls compares each
// result item field by field, in order. The router id is rewritten between
// phases while the unit is idle.
// ---------------------------------------------------------------------------
module tb_distance_vector_update_unit;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int MAX_REPORTS    = 100;
    localparam int RANDOM_PHASES  = 5;
    localparam int PHASE_ITEMS    = 76;

    typedef logic signed [dvu_pkg::COST_BITS-1:0] cost_t;
    typedef logic signed [dvu_pkg::HOP_W-1:0]     hop_t;

    typedef struct {
        dvu_pkg::req_type_t        kind;
        logic [dvu_pkg::IDX_W-1:0] node;
        logic [dvu_pkg::IDX_W-1:0] dest;
        cost_t                     cost;
    } route_req_t;

    typedef struct {
        logic [dvu_pkg::IDX_W-1:0] dest;
        cost_t                     cost;
        hop_t                      hop;
        logic                      changed;
        logic                      last;
    } route_entry_t;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [dvu_pkg::IDX_W-1:0] cfg_wdata;

    dvu_req_if req_ch ();
    dvu_rsp_if rsp_ch ();

    distance_vector_update_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    route_req_t       pending_reqs[$];
    route_entry_t     routes_due[$];
    route_req_t       on_bus;

    cost_t                     direct_cost [dvu_pkg::NODES];
    cost_t                     adv_cost    [dvu_pkg::NODES][dvu_pkg::NODES];
    cost_t                     last_vector [dvu_pkg::NODES];
    hop_t                      next_hop    [dvu_pkg::NODES];
    logic [dvu_pkg::IDX_W-1:0] router_id;

    int               error_count;
    int               send_gap;
    int               recv_stall;
    int               quiet_cycles;
    bit               jitter_on;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    function automatic cost_t random_cost();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12)
            return dvu_pkg::COST_NONE;
        else if (r < 20)
            return cost_t'(32767 - $urandom_range(0, 3));
        else if (r < 50)
            return cost_t'($urandom_range(0, 3));
        else if (r < 85)
            return cost_t'($urandom_range(0, 60));
        else
            return cost_t'($urandom_range(0, 32767));
    endfunction

    task automatic report_mismatch(input string msg);
        if (error_count < MAX_REPORTS)
            $display("MISMATCH @%0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic void recompute_routes();
        cost_t        fresh [dvu_pkg::NODES];
        route_entry_t entry;
        bit           changed;
        int           x;
        int           y;
        changed = 1'b0;
        for (int j = 0; j < dvu_pkg::NODES; j++)
        begin
            x = direct_cost[j];
            for (int k = 0; k < dvu_pkg::NODES; k++)
            begin
                if (k != int'(router_id) && direct_cost[k] >= 0 && adv_cost[k][j] >= 0)
                begin
                    y = int'(direct_cost[k]) + int'(adv_cost[k][j]);
                    if (y > int'(dvu_pkg::COST_MAX))
                        y = int'(dvu_pkg::COST_MAX);
                    if (x < 0 || x > y || (x == y && k != int'(next_hop[j]) && k == j))
                    begin
                        next_hop[j] = hop_t'(k);
                        x = y;
                    end
                end
            end
            fresh[j] = cost_t'(x);
            if (fresh[j] != last_vector[j])
                changed = 1'b1;
        end
        for (int j = 0; j < dvu_pkg::NODES; j++)
        begin
            entry.dest    = dvu_pkg::IDX_W'(j);
            entry.cost    = fresh[j];
            entry.hop     = next_hop[j];
            entry.last    = (j == dvu_pkg::NODES - 1);
            entry.changed = entry.last && changed;
            routes_due.push_back(entry);
            last_vector[j] = fresh[j];
        end
    endfunction

    function automatic void apply_request(input route_req_t r);
        case (r.kind)
            dvu_pkg::REQ_LINK:
            begin
                direct_cost[r.node] = r.cost;
                last_vector[r.node] = r.cost;
                next_hop[r.node]    = (r.cost >= 0) ? hop_t'(r.node) : dvu_pkg::HOP_NONE;
            end
            dvu_pkg::REQ_NBR:
                adv_cost[r.node][r.dest] = r.cost;
            dvu_pkg::REQ_RECOMP:
                recompute_routes();
            default:
                ;
        endcase
    endfunction

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
                apply_request(on_bus);
            if (!req_ch.valid || req_ch.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    req_ch.valid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    on_bus = pending_reqs.pop_front();
                    req_ch.valid      <= 1'b1;
                    req_ch.req_type   <= on_bus.kind;
                    req_ch.node_index <= on_bus.node;
                    req_ch.dest_index <= on_bus.dest;
                    req_ch.cost_value <= on_bus.cost;
                    send_gap = jitter_on ? pick_gap() : 0;
                end
                else
                begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        route_entry_t want;
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (routes_due.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected result for dest %0d",
                                              rsp_ch.out_dest));
                end
                else
                begin
                    want = routes_due.pop_front();
                    if (rsp_ch.out_dest !== want.dest)
                        report_mismatch($sformatf("out_dest %0d, want %0d",
                                                  rsp_ch.out_dest, want.dest));
                    if (rsp_ch.out_cost !== want.cost)
                        report_mismatch($sformatf("dest %0d out_cost %0d, want %0d",
                                                  want.dest, rsp_ch.out_cost, want.cost));
                    if (rsp_ch.out_next_hop !== want.hop)
                        report_mismatch($sformatf("dest %0d out_next_hop %0d, want %0d",
                                                  want.dest, rsp_ch.out_next_hop, want.hop));
                    if (rsp_ch.vector_changed !== want.changed)
                        report_mismatch($sformatf("dest %0d vector_changed %b, want %b",
                                                  want.dest, rsp_ch.vector_changed,
                                                  want.changed));
                    if (rsp_ch.last_entry !== want.last)
                        report_mismatch($sformatf("dest %0d last_entry %b, want %b",
                                                  want.dest, rsp_ch.last_entry, want.last));
                end
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                if (jitter_on && $urandom_range(0, 99) < 20)
                    recv_stall = pick_gap();
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    task automatic queue_req(input dvu_pkg::req_type_t kind, input int node, input int dest,
                             input int cost);
        route_req_t r;
        r.kind = kind;
        r.node = dvu_pkg::IDX_W'(node);
        r.dest = dvu_pkg::IDX_W'(dest);
        r.cost = cost_t'(cost);
        pending_reqs.push_back(r);
    endtask

    // sample after the edge has settled
    task automatic wait_idle();
        do
            @(negedge clk);
        while (pending_reqs.size() != 0 || req_ch.valid || routes_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_router_id(input int id);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= dvu_pkg::IDX_W'(id);
        @(posedge clk);
        cfg_we    <= 1'b0;
        router_id = dvu_pkg::IDX_W'(id);
    endtask

    task automatic queue_random_phase(input int count);
        route_req_t r;
        int         pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (i == count - 1 || (pick >= 82 && pick < 94))
                r.kind = dvu_pkg::REQ_RECOMP;
            else if (pick < 18)
                r.kind = dvu_pkg::REQ_LINK;
            else if (pick < 82)
                r.kind = dvu_pkg::REQ_NBR;
            else
                r.kind = dvu_pkg::REQ_NOP;
            r.node = dvu_pkg::IDX_W'($urandom_range(0, dvu_pkg::NODES - 1));
            r.dest = dvu_pkg::IDX_W'($urandom_range(0, dvu_pkg::NODES - 1));
            r.cost = random_cost();
            pending_reqs.push_back(r);
        end
    endtask

    initial
    begin
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = '0;
        req_ch.valid        = 1'b0;
        req_ch.req_type     = '0;
        req_ch.node_index   = '0;
        req_ch.dest_index   = '0;
        req_ch.cost_value   = '0;
        rsp_ch.ready        = 1'b0;
        error_count         = 0;
        send_gap            = 0;
        recv_stall          = 0;
        quiet_cycles        = 0;
        jitter_on           = 1'b1;
        router_id           = '0;
        for (int i = 0; i < dvu_pkg::NODES; i++)
        begin
            direct_cost[i] = dvu_pkg::COST_NONE;
            last_vector[i] = dvu_pkg::COST_NONE;
            next_hop[i]    = dvu_pkg::HOP_NONE;
            for (int d = 0; d < dvu_pkg::NODES; d++)
                adv_cost[i][d] = dvu_pkg::COST_NONE;
        end

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_router_id(0);
        queue_req(dvu_pkg::REQ_RECOMP, 0, 0, 0);
        queue_req(dvu_pkg::REQ_LINK, 1, 0, 32767);
        queue_req(dvu_pkg::REQ_LINK, 2, 0, 1);
        queue_req(dvu_pkg::REQ_LINK, 3, 0, -1);
        queue_req(dvu_pkg::REQ_LINK, 5, 0, 4);
        queue_req(dvu_pkg::REQ_LINK, 7, 0, 20);
        queue_req(dvu_pkg::REQ_LINK, 6, 0, 5);
        queue_req(dvu_pkg::REQ_NBR, 1, 5, 32767);
        queue_req(dvu_pkg::REQ_NBR, 2, 5, 3);
        queue_req(dvu_pkg::REQ_NBR, 3, 5, 1);
        queue_req(dvu_pkg::REQ_NBR, 0, 5, 0);
        queue_req(dvu_pkg::REQ_LINK, 0, 0, 0);
        queue_req(dvu_pkg::REQ_NBR, 2, 7, 10);
        queue_req(dvu_pkg::REQ_NBR, 7, 7, 0);
        queue_req(dvu_pkg::REQ_NBR, 6, 6, 0);
        queue_req(dvu_pkg::REQ_NBR, 5, 8, -1);
        queue_req(dvu_pkg::REQ_NOP, 15, 15, 32767);
        queue_req(dvu_pkg::REQ_RECOMP, 0, 0, 0);
        queue_req(dvu_pkg::REQ_RECOMP, 15, 15, -1);
        queue_req(dvu_pkg::REQ_NBR, 2, 7, 30);
        queue_req(dvu_pkg::REQ_RECOMP, 0, 0, 0);

        set_router_id(2);
        queue_req(dvu_pkg::REQ_RECOMP, 0, 0, 0);

        set_router_id(15);
        queue_req(dvu_pkg::REQ_NBR, 15, 15, 32767);
        queue_req(dvu_pkg::REQ_LINK, 15, 15, 0);
        queue_req(dvu_pkg::REQ_RECOMP, 0, 0, 0);

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:       set_router_id(15);
                1:       set_router_id(0);
                default: set_router_id($urandom_range(1, 14));
            endcase
            jitter_on = (p != 2);
            queue_random_phase(PHASE_ITEMS);
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

[files.f]
rtl/core/dvu_pkg.sv
rtl/core/dvu_req_if.sv
rtl/core/dvu_rsp_if.sv
rtl/core/dvu_ctrl.sv
rtl/core/dvu_datapath.sv
rtl/core/distance_vector_update_unit.sv
sim/tb_distance_vector_update_unit.sv
